@@ rtl/core/depth_to_point_backprojection_defines.svh @@
`ifndef DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH

// same-cycle implication
`define DBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dbp_pkg.sv @@
package dbp_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int DEPTH_BITS_DEFAULT = 16;

   localparam int MID_QUEUE_DEPTH = 4;
   localparam int OUT_QUEUE_DEPTH = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int SIZE_BITS      = 13;
   localparam int RSP_BITS       = 32 + 32 + 31 + 1;

   localparam logic [31:0]          RESET_INV_FOCAL = 32'd8180890;
   localparam logic [15:0]          RESET_CENTER_X  = 16'd5112;
   localparam logic [15:0]          RESET_CENTER_Y  = 16'd3832;
   localparam logic [31:0]          RESET_INV_DEPTH = 32'd858993;
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH     = 13'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT    = 13'd480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INV_FOCAL_X,
      CSR_INV_FOCAL_Y,
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_INV_DEPTH_SCALE,
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [31:0]          inv_focal_x;
      logic [31:0]          inv_focal_y;
      logic [15:0]          center_x;
      logic [15:0]          center_y;
      logic [31:0]          inv_depth_scale;
      logic [SIZE_BITS-1:0] frame_width;
      logic [SIZE_BITS-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/dbp_fifo.sv @@
module dbp_fifo
   import dbp_pkg::*;
#(
   parameter int WIDTH = RSP_BITS,
   parameter int DEPTH = OUT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop_en,
   output logic [WIDTH-1:0] rdata,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push_en && !status.full;
   assign do_pop       = pop_en && !status.empty;
   assign rdata        = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/dbp_front.sv @@
module dbp_front
   import dbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT,
   parameter int MAG_W      = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16,
   parameter int ITEM_W     = DEPTH_BITS + 2 * (MAG_W + 1) + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [15:0]       req_depth_sample,
   output logic              full,
   input  cfg_type           cfg,
   input  queue_status_type  mid_status,
   output logic              mid_push,
   output logic [ITEM_W-1:0] mid_item
);

   localparam int SIZE_W = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam int D_W    = MAG_W + 1;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_last, row_last;
   logic                  last_col, last_row;
   logic [D_W-1:0]        dx, dy;
   logic [MAG_W-1:0]      mag_x, mag_y;
   logic                  accept;

   function automatic logic [COORD_BITS-1:0] last_index(input logic [SIZE_BITS-1:0] size);
      logic [SIZE_W-1:0] lim;
      logic [SIZE_W-1:0] ext;
      logic [SIZE_W-1:0] eff;
      lim = SIZE_W'(1) << COORD_BITS;
      ext = SIZE_W'(size);
      if (ext == '0) begin
         eff = SIZE_W'(1);
      end else if (ext > lim) begin
         eff = lim;
      end else begin
         eff = ext;
      end
      return COORD_BITS'(eff - SIZE_W'(1));
   endfunction

   assign full     = mid_status.full;
   assign accept   = push && !mid_status.full;
   assign mid_push = accept;

   assign col_last = last_index(cfg.frame_width);
   assign row_last = last_index(cfg.frame_height);
   assign last_col = (col_ff >= col_last);
   assign last_row = (row_ff >= row_last);

   assign dx    = D_W'({col_ff, 4'b0000}) - D_W'(cfg.center_x);
   assign dy    = D_W'({row_ff, 4'b0000}) - D_W'(cfg.center_y);
   assign mag_x = dx[D_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
   assign mag_y = dy[D_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];

   assign mid_item = {last_col && last_row, dy[D_W-1], mag_y, dx[D_W-1], mag_x,
                      req_depth_sample[DEPTH_BITS-1:0]};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : COORD_BITS'(row_ff + 1'b1);
         end else begin
            col_in = COORD_BITS'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/core/dbp_back.sv @@
module dbp_back
   import dbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT,
   parameter int MAG_W      = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16,
   parameter int ITEM_W     = DEPTH_BITS + 2 * (MAG_W + 1) + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  queue_status_type    mid_status,
   input  logic [ITEM_W-1:0]   mid_item,
   output logic                mid_pop,
   input  logic                rsp_xfer,
   output logic                out_push,
   output logic [RSP_BITS-1:0] out_item
);

   localparam int P_W   = DEPTH_BITS + 32;
   localparam int M_W   = MAG_W + 32;
   localparam int H_W   = MAG_W + 33;
   localparam int R_W   = H_W - 4;
   localparam int CRD_W = $clog2(OUT_QUEUE_DEPTH + 1);

   logic [DEPTH_BITS-1:0] in_depth;
   logic [MAG_W-1:0]      in_mag_x, in_mag_y;
   logic                  in_neg_x, in_neg_y, in_end;
   logic [CRD_W-1:0]      credit_ff, credit_in;
   logic [P_W-1:0]        zprod;

   // stage 1: depth
   logic                  s1_vld_ff;
   logic [31:0]           s1_z_ff;
   logic [MAG_W-1:0]      s1_mag_x_ff, s1_mag_y_ff;
   logic                  s1_neg_x_ff, s1_neg_y_ff, s1_end_ff;
   // stage 2: offset times depth
   logic                  s2_vld_ff;
   logic [M_W-1:0]        s2_mx_ff, s2_my_ff;
   logic [30:0]           s2_z_ff;
   logic                  s2_neg_x_ff, s2_neg_y_ff, s2_end_ff;
   // stage 3: low partial products
   logic                  s3_vld_ff;
   logic [63:0]           s3_lx_ff, s3_ly_ff;
   logic [MAG_W-1:0]      s3_hx_ff, s3_hy_ff;
   logic [30:0]           s3_z_ff;
   logic                  s3_neg_x_ff, s3_neg_y_ff, s3_end_ff;
   // stage 4: high partial products and rounding
   logic                  s4_vld_ff;
   logic [R_W-1:0]        s4_rx_ff, s4_ry_ff;
   logic [30:0]           s4_z_ff;
   logic                  s4_neg_x_ff, s4_neg_y_ff, s4_end_ff;

   logic [64:0]           lrx, lry;
   logic [H_W-1:0]        hx, hy;

   function automatic logic [31:0] saturate(input logic neg, input logic [R_W-1:0] r);
      logic [31:0] res;
      if (neg) begin
         res = (r > R_W'(33'h080000000)) ? 32'h80000000 : (~r[31:0] + 32'd1);
      end else begin
         res = (r > R_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : r[31:0];
      end
      return res;
   endfunction

   assign {in_end, in_neg_y, in_mag_y, in_neg_x, in_mag_x, in_depth} = mid_item;

   assign mid_pop = !mid_status.empty && (credit_ff < CRD_W'(OUT_QUEUE_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (mid_pop && !rsp_xfer) begin
         credit_in = CRD_W'(credit_ff + 1'b1);
      end else if (rsp_xfer && !mid_pop) begin
         credit_in = CRD_W'(credit_ff - 1'b1);
      end
   end

   assign zprod = P_W'(in_depth) * P_W'(cfg.inv_depth_scale) + P_W'(32'h8000);

   assign lrx = 65'(s3_lx_ff) + (65'd1 << 35);
   assign lry = 65'(s3_ly_ff) + (65'd1 << 35);
   assign hx  = H_W'(s3_hx_ff) * H_W'(cfg.inv_focal_x) + H_W'(lrx[64:32]);
   assign hy  = H_W'(s3_hy_ff) * H_W'(cfg.inv_focal_y) + H_W'(lry[64:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         s1_vld_ff <= mid_pop;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_z_ff     <= 32'(zprod >> 16);
      s1_mag_x_ff <= in_mag_x;
      s1_mag_y_ff <= in_mag_y;
      s1_neg_x_ff <= in_neg_x;
      s1_neg_y_ff <= in_neg_y;
      s1_end_ff   <= in_end;

      s2_mx_ff    <= M_W'(s1_mag_x_ff) * M_W'(s1_z_ff);
      s2_my_ff    <= M_W'(s1_mag_y_ff) * M_W'(s1_z_ff);
      s2_z_ff     <= s1_z_ff[31] ? 31'h7FFFFFFF : s1_z_ff[30:0];
      s2_neg_x_ff <= s1_neg_x_ff;
      s2_neg_y_ff <= s1_neg_y_ff;
      s2_end_ff   <= s1_end_ff;

      s3_lx_ff    <= 64'(s2_mx_ff[31:0]) * 64'(cfg.inv_focal_x);
      s3_ly_ff    <= 64'(s2_my_ff[31:0]) * 64'(cfg.inv_focal_y);
      s3_hx_ff    <= s2_mx_ff[M_W-1:32];
      s3_hy_ff    <= s2_my_ff[M_W-1:32];
      s3_z_ff     <= s2_z_ff;
      s3_neg_x_ff <= s2_neg_x_ff;
      s3_neg_y_ff <= s2_neg_y_ff;
      s3_end_ff   <= s2_end_ff;

      s4_rx_ff    <= hx[H_W-1:4];
      s4_ry_ff    <= hy[H_W-1:4];
      s4_z_ff     <= s3_z_ff;
      s4_neg_x_ff <= s3_neg_x_ff;
      s4_neg_y_ff <= s3_neg_y_ff;
      s4_end_ff   <= s3_end_ff;
   end

   assign out_push = s4_vld_ff;
   assign out_item = {s4_end_ff, s4_z_ff, saturate(s4_neg_y_ff, s4_ry_ff),
                      saturate(s4_neg_x_ff, s4_rx_ff)};

endmodule

@@ rtl/core/depth_to_point_backprojection.sv @@
// Depth image to point cloud back-projection. Depth pixels enter in raster order through
// push/full, one per clock while full is low; column and row are counted against frame_width and
// frame_height, and each pixel leaves as one point (X, Y, Z in Q15.16 metres, saturated) with
// frame_end on the frame's last pixel, through empty/pop in arrival order. A point passes from
// its pixel's transfer through the 4-entry input queue and the multiplier pipeline stages (depth
// scale, offset times depth, then the reciprocal focal product in low and high halves), whose
// last stage writes the 8-entry result queue. The pipeline issues only while the result queue
// has a free entry reserved, so full rises once both queues are occupied by results that are
// not popped. Write the registers only while no pixel is in flight; the counters keep their
// position across register writes.
module depth_to_point_backprojection
   import dbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [15:0]               req_depth_sample,
   output logic                      full,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [31:0]        rsp_point_x,
   output logic signed [31:0]        rsp_point_y,
   output logic [30:0]               rsp_point_z,
   output logic                      rsp_frame_end,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int MAG_W  = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
   localparam int ITEM_W = DEPTH_BITS + 2 * (MAG_W + 1) + 1;

   cfg_type             cfg_ff, cfg_in;
   queue_status_type    mid_status, out_status;
   logic                mid_push, mid_pop;
   logic [ITEM_W-1:0]   mid_wdata, mid_rdata;
   logic                out_push, rsp_xfer;
   logic [RSP_BITS-1:0] out_wdata, out_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_FOCAL_X:     cfg_in.inv_focal_x     = csr_wdata;
            CSR_INV_FOCAL_Y:     cfg_in.inv_focal_y     = csr_wdata;
            CSR_CENTER_X:        cfg_in.center_x        = csr_wdata[15:0];
            CSR_CENTER_Y:        cfg_in.center_y        = csr_wdata[15:0];
            CSR_INV_DEPTH_SCALE: cfg_in.inv_depth_scale = csr_wdata;
            CSR_FRAME_WIDTH:     cfg_in.frame_width     = csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT:    cfg_in.frame_height    = csr_wdata[SIZE_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_focal_x     <= RESET_INV_FOCAL;
         cfg_ff.inv_focal_y     <= RESET_INV_FOCAL;
         cfg_ff.center_x        <= RESET_CENTER_X;
         cfg_ff.center_y        <= RESET_CENTER_Y;
         cfg_ff.inv_depth_scale <= RESET_INV_DEPTH;
         cfg_ff.frame_width     <= RESET_WIDTH;
         cfg_ff.frame_height    <= RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbp_front #(
      .COORD_BITS (COORD_BITS),
      .DEPTH_BITS (DEPTH_BITS),
      .MAG_W      (MAG_W),
      .ITEM_W     (ITEM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_depth_sample (req_depth_sample),
      .full             (full),
      .cfg              (cfg_ff),
      .mid_status       (mid_status),
      .mid_push         (mid_push),
      .mid_item         (mid_wdata)
   );

   dbp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push_en (mid_push),
      .wdata   (mid_wdata),
      .pop_en  (mid_pop),
      .rdata   (mid_rdata),
      .status  (mid_status)
   );

   dbp_back #(
      .COORD_BITS (COORD_BITS),
      .DEPTH_BITS (DEPTH_BITS),
      .MAG_W      (MAG_W),
      .ITEM_W     (ITEM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mid_status (mid_status),
      .mid_item   (mid_rdata),
      .mid_pop    (mid_pop),
      .rsp_xfer   (rsp_xfer),
      .out_push   (out_push),
      .out_item   (out_wdata)
   );

   dbp_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (OUT_QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push_en (out_push),
      .wdata   (out_wdata),
      .pop_en  (pop),
      .rdata   (out_rdata),
      .status  (out_status)
   );

   assign empty    = out_status.empty;
   assign rsp_xfer = pop && !out_status.empty;

   assign rsp_point_x   = $signed(out_rdata[31:0]);
   assign rsp_point_y   = $signed(out_rdata[63:32]);
   assign rsp_point_z   = out_rdata[94:64];
   assign rsp_frame_end = out_rdata[95];

endmodule

@@ rtl/core/dbp_checker.sv @@
`include "depth_to_point_backprojection_defines.svh"

module dbp_checker (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic signed [31:0] rsp_point_x,
   input logic signed [31:0] rsp_point_y,
   input logic [30:0]        rsp_point_z,
   input logic               rsp_frame_end
);

   logic [15:0] pending_ff, pending_in;
   logic        req_xfer, rsp_xfer;

   assign req_xfer = push && !full;
   assign rsp_xfer = pop && !empty;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer && pending_ff != 16'hFFFF) begin
         pending_in = pending_ff + 16'd1;
      end else if (rsp_xfer && !req_xfer && pending_ff != 16'd0) begin
         pending_in = pending_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DBP_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z) && $stable(rsp_frame_end), "result changed while stalled")
   `DBP_ASSERT_NOW(a_zero_depth, clock, reset, !empty && rsp_point_z == 31'd0, rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0, "lateral coordinate nonzero at zero depth")
   `DBP_ASSERT_NOW(a_no_invented, clock, reset, !empty, pending_ff != 16'd0, "result shown with no pixel outstanding")

endmodule

bind depth_to_point_backprojection dbp_checker u_checker (.*);
